// ===== rtl/gtp_pkg.sv =====
// gtp_pkg: shared constants, types and the hex decode function for the GUID text parser
// no dependencies
package gtp_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned GuidW  = 2 * HalfW;
  localparam int unsigned PosW   = 6;
  localparam int unsigned DigitW = 4;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // total lengths of the three accepted forms
  localparam logic [PosW-1:0] LenPlain  = PosW'(32);
  localparam logic [PosW-1:0] LenDashed = PosW'(36);
  localparam logic [PosW-1:0] LenBraced = PosW'(38);

  // separator positions, dashed form
  localparam logic [PosW-1:0] DashPos0 = PosW'(8);
  localparam logic [PosW-1:0] DashPos1 = PosW'(13);
  localparam logic [PosW-1:0] DashPos2 = PosW'(18);
  localparam logic [PosW-1:0] DashPos3 = PosW'(23);
  // braced form is shifted by one
  localparam logic [PosW-1:0] BraceOpenPos  = PosW'(0);
  localparam logic [PosW-1:0] BraceClosePos = PosW'(37);

  localparam logic [CharW-1:0] CharDash       = 16'h002D;
  localparam logic [CharW-1:0] CharBraceOpen  = 16'h007B;
  localparam logic [CharW-1:0] CharBraceClose = 16'h007D;

  typedef struct packed {
    logic              is_hex;
    logic [DigitW-1:0] value;
  } hex_digit_t;

  typedef struct packed {
    logic [HalfW-1:0] guid_high;
    logic [HalfW-1:0] guid_low;
  } guid_t;

  function automatic hex_digit_t hex_decode(input logic [CharW-1:0] c);
    hex_digit_t r;
    r.is_hex = 1'b0;
    r.value  = '0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r.is_hex = 1'b1;
      r.value  = DigitW'(c - 16'h0030);
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      r.is_hex = 1'b1;
      r.value  = DigitW'(c - 16'h0041 + 16'd10);
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      r.is_hex = 1'b1;
      r.value  = DigitW'(c - 16'h0061 + 16'd10);
    end
    return r;
  endfunction

endpackage

// ===== rtl/gtp_char_if.sv =====
// gtp_char_if: valid/ready channel carrying one text character
// depends on gtp_pkg
interface gtp_char_if;
  logic                       valid;
  logic                       ready;
  logic [gtp_pkg::CharW-1:0]  character;
  logic                       final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink   (input valid, input character, input final_char, output ready);
endinterface

// ===== rtl/gtp_guid_if.sv =====
// gtp_guid_if: valid/ready channel carrying one parsed 128-bit GUID
// depends on gtp_pkg
interface gtp_guid_if;
  logic                       valid;
  logic                       ready;
  logic [gtp_pkg::HalfW-1:0]  guid_high;
  logic [gtp_pkg::HalfW-1:0]  guid_low;

  modport source (output valid, output guid_high, output guid_low, input ready);
  modport sink   (input valid, input guid_high, input guid_low, output ready);
endinterface

// ===== rtl/gtp_in_reg.sv =====
// gtp_in_reg: input register stage holding one accepted character
// depends on gtp_pkg
module gtp_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gtp_pkg::CharW-1:0] in_char_i,
  input  logic                      in_last_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output logic [gtp_pkg::CharW-1:0] char_o,
  output logic                      last_o
);

  logic                      valid_q, valid_d;
  logic [gtp_pkg::CharW-1:0] char_q;
  logic                      last_q;
  logic                      load;

  // take a new character when empty or when the held one leaves this cycle
  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= in_char_i;
      last_q <= in_last_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

endmodule

// ===== rtl/gtp_form_track.sv =====
// gtp_form_track: position counter, digit shift register and form checks
// depends on gtp_pkg
module gtp_form_track (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [gtp_pkg::CharW-1:0] char_i,
  input  logic                      last_i,
  output gtp_pkg::guid_t            result_o
);

  logic [gtp_pkg::PosW-1:0]  pos_q, pos_d;
  logic [gtp_pkg::GuidW-1:0] acc_q, acc_d;
  logic plain_ok_q, plain_ok_d;
  logic dashed_ok_q, dashed_ok_d;
  logic braced_ok_q, braced_ok_d;

  gtp_pkg::hex_digit_t       dig;
  logic                      is_dash;
  logic                      dash_slot, brace_dash_slot;
  logic [gtp_pkg::PosW-1:0]  pos_nx;
  logic [gtp_pkg::GuidW-1:0] acc_nx;
  logic plain_nx, dashed_nx, braced_nx;
  logic ok;

  assign dig     = gtp_pkg::hex_decode(char_i);
  assign is_dash = (char_i == gtp_pkg::CharDash);

  assign dash_slot = (pos_q == gtp_pkg::DashPos0) || (pos_q == gtp_pkg::DashPos1) ||
                     (pos_q == gtp_pkg::DashPos2) || (pos_q == gtp_pkg::DashPos3);
  assign brace_dash_slot = (pos_q == gtp_pkg::DashPos0 + 1'b1) ||
                           (pos_q == gtp_pkg::DashPos1 + 1'b1) ||
                           (pos_q == gtp_pkg::DashPos2 + 1'b1) ||
                           (pos_q == gtp_pkg::DashPos3 + 1'b1);

  always_comb begin
    plain_nx = plain_ok_q;
    if (pos_q >= gtp_pkg::LenPlain || !dig.is_hex) begin
      plain_nx = 1'b0;
    end

    dashed_nx = dashed_ok_q;
    if (pos_q >= gtp_pkg::LenDashed) begin
      dashed_nx = 1'b0;
    end else if (dash_slot) begin
      if (!is_dash) dashed_nx = 1'b0;
    end else if (!dig.is_hex) begin
      dashed_nx = 1'b0;
    end

    braced_nx = braced_ok_q;
    if (pos_q >= gtp_pkg::LenBraced) begin
      braced_nx = 1'b0;
    end else if (pos_q == gtp_pkg::BraceOpenPos) begin
      if (char_i != gtp_pkg::CharBraceOpen) braced_nx = 1'b0;
    end else if (pos_q == gtp_pkg::BraceClosePos) begin
      if (char_i != gtp_pkg::CharBraceClose) braced_nx = 1'b0;
    end else if (brace_dash_slot) begin
      if (!is_dash) braced_nx = 1'b0;
    end else if (!dig.is_hex) begin
      braced_nx = 1'b0;
    end

    // shift in one hex digit, most significant first
    acc_nx = acc_q;
    if (dig.is_hex) begin
      acc_nx = {acc_q[gtp_pkg::GuidW-gtp_pkg::DigitW-1:0], dig.value};
    end

    // saturating position count
    pos_nx = (pos_q == gtp_pkg::PosMax) ? pos_q : pos_q + 1'b1;
  end

  assign ok = ((pos_nx == gtp_pkg::LenPlain)  && plain_nx)  ||
              ((pos_nx == gtp_pkg::LenDashed) && dashed_nx) ||
              ((pos_nx == gtp_pkg::LenBraced) && braced_nx);

  assign result_o.guid_high = ok ? acc_nx[gtp_pkg::GuidW-1:gtp_pkg::HalfW] : '0;
  assign result_o.guid_low  = ok ? acc_nx[gtp_pkg::HalfW-1:0] : '0;

  always_comb begin
    pos_d       = pos_q;
    acc_d       = acc_q;
    plain_ok_d  = plain_ok_q;
    dashed_ok_d = dashed_ok_q;
    braced_ok_d = braced_ok_q;
    if (step_i) begin
      if (last_i) begin
        // end of string: back to the start state
        pos_d       = '0;
        acc_d       = '0;
        plain_ok_d  = 1'b1;
        dashed_ok_d = 1'b1;
        braced_ok_d = 1'b1;
      end else begin
        pos_d       = pos_nx;
        acc_d       = acc_nx;
        plain_ok_d  = plain_nx;
        dashed_ok_d = dashed_nx;
        braced_ok_d = braced_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      acc_q       <= '0;
      plain_ok_q  <= 1'b1;
      dashed_ok_q <= 1'b1;
      braced_ok_q <= 1'b1;
    end else begin
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      plain_ok_q  <= plain_ok_d;
      dashed_ok_q <= dashed_ok_d;
      braced_ok_q <= braced_ok_d;
    end
  end

endmodule

// ===== rtl/guid_text_parser.sv =====
// guid_text_parser: top level, input register, form tracker and result register
// depends on gtp_pkg, gtp_char_if, gtp_guid_if, gtp_in_reg, gtp_form_track
//
//  channel  | dir | payload                    | transfer
//  ---------+-----+----------------------------+------------------------------
//  in_i     | in  | character[16], final_char  | one character of the text
//  out_o    | out | guid_high[64], guid_low[64]| one value per final character
//
// one character per cycle sustained while no final character waits on the output;
// a character passes the input register, and the final one's result is registered in
// the result register as it leaves, raising out_o.valid. reset clears the position
// and digit register and sets the form flags. a stalled output only holds the final
// character in the input register; other characters keep flowing while a result waits.
module guid_text_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  gtp_char_if.sink   in_i,
  gtp_guid_if.source out_o
);

  logic                      s1_valid;
  logic [gtp_pkg::CharW-1:0] s1_char;
  logic                      s1_last;
  logic                      s1_pop;
  logic                      out_free;
  gtp_pkg::guid_t            result;

  logic                      out_valid_q, out_valid_d;
  gtp_pkg::guid_t            out_q;

  assign out_free = !out_valid_q || out_o.ready;
  // a final character needs room in the result register
  assign s1_pop   = s1_valid && (!s1_last || out_free);

  gtp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_char_i  (in_i.character),
    .in_last_i  (in_i.final_char),
    .pop_i      (s1_pop),
    .valid_o    (s1_valid),
    .char_o     (s1_char),
    .last_o     (s1_last)
  );

  gtp_form_track u_form_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_pop),
    .char_i   (s1_char),
    .last_i   (s1_last),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_pop && s1_last) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_pop && s1_last) begin
      out_q <= result;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.guid_high = out_q.guid_high;
  assign out_o.guid_low  = out_q.guid_low;

endmodule

// ===== tb/guid_text_parser_tb.sv =====
// guid_text_parser_tb: self-checking bench for the GUID text parser, directed table then
// random texts in all three forms, broken and noisy, checked against a local parse model
// depends on gtp_pkg, gtp_char_if, gtp_guid_if and guid_text_parser
module guid_text_parser_tb;

  typedef enum int {CHK_MODEL, CHK_ZERO, CHK_ONES} check_kind_e;

  localparam int CycleLimit = 200000;
  localparam int TotalItems = 1650;
  localparam int DirRows    = 21;

  localparam logic [5:0] PlainLen  = 6'd32;
  localparam logic [5:0] DashedLen = 6'd36;
  localparam logic [5:0] BracedLen = 6'd38;
  localparam logic [5:0] DashAt0   = 6'd8;
  localparam logic [5:0] DashAt1   = 6'd13;
  localparam logic [5:0] DashAt2   = 6'd18;
  localparam logic [5:0] DashAt3   = 6'd23;
  localparam logic [5:0] OpenAt    = 6'd0;
  localparam logic [5:0] CloseAt   = 6'd37;
  localparam logic [5:0] PosTop    = 6'd63;

  localparam logic [gtp_pkg::CharW-1:0] ChHyphen = 16'h002D;
  localparam logic [gtp_pkg::CharW-1:0] ChOpen   = 16'h007B;
  localparam logic [gtp_pkg::CharW-1:0] ChClose  = 16'h007D;
  localparam logic [gtp_pkg::CharW-1:0] ChZero   = 16'h0030;
  localparam logic [gtp_pkg::CharW-1:0] ChUpA    = 16'h0041;
  localparam logic [gtp_pkg::CharW-1:0] ChLowA   = 16'h0061;
  localparam logic [gtp_pkg::CharW-1:0] ChGrave  = 16'h0060;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gtp_char_if char_ch ();
  gtp_guid_if guid_ch ();

  guid_text_parser i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (char_ch),
    .out_o  (guid_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // directed texts; a wide character can replace one position of a row
  string row_text [DirRows] = '{
    "{",
    "0",
    "00000000000000000000000000000000",
    "FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF",
    "ffffffff-ffff-ffff-ffff-ffffffffffff",
    "{FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF}",
    "0123456789abcdefABCDEF0123456789",
    "01234567-89ab-cdef-0123-456789ABCDEF",
    "{01234567-89AB-CDEF-0123-456789abcdef}",
    "0123456789abcdef0123456789abcdef0",
    "0123456789abcdef0123456789abcde",
    "01234567x89ab-cdef-0123-456789abcdef",
    "{01234567-89ab-cdef-0123-456789abcdef]",
    "0123456789abcdef0123456789abcdeg",
    "0123456789abcdef0123456789abcdef",
    "{1234567-89ab-cdef-0123-456789abcde}",
    "aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa",
    "99999999999999999999999999999999999999",
    "x01234567-89ab-cdef-0123-456789abcdef}",
    "01234567-9abcdef0123456789abcdef",
    "9AFaf09AFaf09AFaf09AFaf09AFaf09A"
  };
  int row_wide_at [DirRows] = '{-1, 0, -1, -1, -1, -1, -1, -1, -1, -1, -1,
                                -1, -1, -1, 5, -1, -1, -1, -1, -1, 31};
  logic [gtp_pkg::CharW-1:0] row_wide_ch [DirRows] = '{
    16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0,
    16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
    16'h0, 16'h0, 16'h0, 16'h0135, 16'h0,
    16'h0, 16'h0, 16'h0, 16'h0, 16'h8041
  };
  check_kind_e row_check [DirRows] = '{
    CHK_ZERO, CHK_ZERO, CHK_ZERO, CHK_ONES, CHK_ONES, CHK_ONES, CHK_MODEL,
    CHK_MODEL, CHK_MODEL, CHK_ZERO, CHK_ZERO, CHK_ZERO, CHK_ZERO, CHK_ZERO,
    CHK_ZERO, CHK_ZERO, CHK_ZERO, CHK_ZERO, CHK_ZERO, CHK_ZERO, CHK_ZERO
  };

  logic [gtp_pkg::CharW-1:0] stim_char [$];
  bit                        stim_last [$];
  check_kind_e               stim_check [$];

  gtp_pkg::guid_t pending_guids [$];
  int    n_taken = 0;
  int    mismatches = 0;
  int    cycles = 0;

  // parse model state
  logic [5:0]   cur_pos;
  logic [127:0] digits;
  bit           fits_plain, fits_dashed, fits_braced;

  function automatic void clear_parse();
    cur_pos     = '0;
    digits      = '0;
    fits_plain  = 1'b1;
    fits_dashed = 1'b1;
    fits_braced = 1'b1;
  endfunction

  // {is hex, value}
  function automatic logic [4:0] hex_nibble(input logic [gtp_pkg::CharW-1:0] ch);
    if (ch >= ChZero && ch <= ChZero + 9) return {1'b1, ch[3:0]};
    if ((ch >= ChUpA && ch <= ChUpA + 5) || (ch >= ChLowA && ch <= ChLowA + 5))
      return {1'b1, ch[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic bit track_char(input logic [gtp_pkg::CharW-1:0] ch, input logic last,
                                    output gtp_pkg::guid_t value);
    logic [4:0] nib;
    logic       dash;
    nib   = hex_nibble(ch);
    dash  = (ch == ChHyphen);
    value = '0;
    if (cur_pos >= PlainLen || !nib[4]) fits_plain = 1'b0;
    if (cur_pos >= DashedLen) begin
      fits_dashed = 1'b0;
    end else if (cur_pos == DashAt0 || cur_pos == DashAt1 || cur_pos == DashAt2 ||
                 cur_pos == DashAt3) begin
      if (!dash) fits_dashed = 1'b0;
    end else if (!nib[4]) begin
      fits_dashed = 1'b0;
    end
    // braced form: the dashed layout moved one place right
    if (cur_pos >= BracedLen) begin
      fits_braced = 1'b0;
    end else if (cur_pos == OpenAt) begin
      if (ch != ChOpen) fits_braced = 1'b0;
    end else if (cur_pos == CloseAt) begin
      if (ch != ChClose) fits_braced = 1'b0;
    end else if (cur_pos == DashAt0 + 1 || cur_pos == DashAt1 + 1 ||
                 cur_pos == DashAt2 + 1 || cur_pos == DashAt3 + 1) begin
      if (!dash) fits_braced = 1'b0;
    end else if (!nib[4]) begin
      fits_braced = 1'b0;
    end
    if (nib[4]) digits = {digits[123:0], nib[3:0]};
    if (cur_pos != PosTop) cur_pos = cur_pos + 1'b1;
    if (!last) return 1'b0;
    if ((cur_pos == PlainLen && fits_plain) || (cur_pos == DashedLen && fits_dashed) ||
        (cur_pos == BracedLen && fits_braced))
      value = digits;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void queue_char(input logic [gtp_pkg::CharW-1:0] ch, input bit last,
                                     input check_kind_e chk);
    stim_char.push_back(ch);
    stim_last.push_back(last);
    stim_check.push_back(chk);
  endfunction

  function automatic logic [gtp_pkg::CharW-1:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return ChZero + gtp_pkg::CharW'(d);
    return ($urandom_range(0, 1) ? ChUpA : ChLowA) + gtp_pkg::CharW'(d - 10);
  endfunction

  // separators, braces and characters just outside the hex ranges
  function automatic logic [gtp_pkg::CharW-1:0] odd_char();
    string pool;
    pool = "/:@G[g-{}x h";
    if ($urandom_range(0, 12) == 0) return ChGrave;
    return gtp_pkg::CharW'(pool[$urandom_range(0, pool.len() - 1)]);
  endfunction

  function automatic logic [gtp_pkg::CharW-1:0] noise_char();
    case ($urandom_range(0, 3))
      0: return gtp_pkg::CharW'($urandom_range(0, 16'hFFFF));
      1: return odd_char();
      default: return hex_char();
    endcase
  endfunction

  function automatic void add_random_text();
    logic [gtp_pkg::CharW-1:0] txt [$];
    int kind, form, n, k;
    kind = $urandom_range(0, 99);
    form = $urandom_range(0, 2);
    if (kind < 80) begin
      if (form == 2) txt.push_back(ChOpen);
      for (int i = 0; i < 32; i++) begin
        if (form != 0 && (i == 8 || i == 12 || i == 16 || i == 20)) txt.push_back(ChHyphen);
        txt.push_back(hex_char());
      end
      if (form == 2) txt.push_back(ChClose);
      // broken variants of a well-formed text
      if (kind >= 60) begin
        k = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 3))
          0: txt[k] = gtp_pkg::CharW'($urandom_range(0, 16'hFFFF));
          1: txt[k] = odd_char();
          2: txt.delete(k);
          default: txt.insert(k, noise_char());
        endcase
      end
    end else begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 40);
      for (int i = 0; i < n; i++) txt.push_back(noise_char());
    end
    foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1, CHK_MODEL);
  endfunction

  // every character transfer feeds the parse model
  always @(posedge clk) begin : take_char
    gtp_pkg::guid_t value;
    if (rst_n && char_ch.valid && char_ch.ready) begin
      if (track_char(char_ch.character, char_ch.final_char, value)) begin
        case (stim_check[n_taken])
          CHK_ZERO: pending_guids.push_back('0);
          CHK_ONES: pending_guids.push_back('1);
          default:  pending_guids.push_back(value);
        endcase
      end
      n_taken++;
    end
  end

  always @(posedge clk) begin : check_guid
    gtp_pkg::guid_t want;
    if (rst_n && guid_ch.valid && guid_ch.ready) begin
      if (pending_guids.size() == 0) begin
        $display("%0t: guid with none expected, got %h %h", $time,
                 guid_ch.guid_high, guid_ch.guid_low);
        mismatches++;
      end else begin
        want = pending_guids.pop_front();
        if (guid_ch.guid_high !== want.guid_high) begin
          $display("%0t: guid_high expected %h got %h", $time, want.guid_high,
                   guid_ch.guid_high);
          mismatches++;
        end
        if (guid_ch.guid_low !== want.guid_low) begin
          $display("%0t: guid_low expected %h got %h", $time, want.guid_low,
                   guid_ch.guid_low);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off that backs up the input
  initial begin : out_stall
    int cyc, hold, mode;
    bit held;
    cyc  = 0;
    hold = 0;
    mode = 0;
    held = 1'b0;
    guid_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (!held && n_taken >= 800) begin
        held = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        guid_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: guid_ch.ready <= 1'b1;
          1: guid_ch.ready <= 1'($urandom_range(0, 1));
          2: guid_ch.ready <= (cyc % 4 == 0);
          default: guid_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin : run
    int idx, burst_left, gap;
    char_ch.valid      <= 1'b0;
    char_ch.character  <= '0;
    char_ch.final_char <= 1'b0;
    clear_parse();

    for (int r = 0; r < DirRows; r++) begin
      for (int i = 0; i < row_text[r].len(); i++) begin
        queue_char((i == row_wide_at[r]) ? row_wide_ch[r] :
                                           gtp_pkg::CharW'(row_text[r][i]),
                   i == row_text[r].len() - 1, row_check[r]);
      end
    end
    while (stim_char.size() < TotalItems) add_random_text();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx        = 0;
    burst_left = 0;
    while (idx < stim_char.size()) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        if (gap > 0) begin
          char_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      char_ch.valid      <= 1'b1;
      char_ch.character  <= stim_char[idx];
      char_ch.final_char <= stim_last[idx];
      @(posedge clk);
      while (!char_ch.ready) @(posedge clk);
      idx++;
      burst_left--;
    end
    char_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending_guids.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gtp_pkg.sv
rtl/gtp_char_if.sv
rtl/gtp_guid_if.sv
rtl/gtp_in_reg.sv
rtl/gtp_form_track.sv
rtl/guid_text_parser.sv
tb/guid_text_parser_tb.sv
